// ----- design/lfap_pkg.sv -----
// lfap_pkg: shared types and constants of the led frame animation player
// commands, sequencer states, register indexes, field widths and reset values
// no dependencies
package lfap_pkg;

	// input field widths
	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 12;
	localparam int BYTE_W   = 8;
	localparam int S_DATA_W = 24;

	// output field widths
	localparam int LED_W    = 6;
	localparam int M_DATA_W = 16;

	// configuration port
	localparam int REG_IDX_W = 2;
	localparam int REG_DATA_W = 16;
	localparam int TICK_W   = 16;
	localparam int FRAMES_W = 7;
	localparam int REPEAT_W = 8;
	localparam int INDEX_W  = 6;

	localparam logic [REG_IDX_W-1:0] REG_TICK_INTERVAL  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_LOOP = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_TOTAL   = 2'd2;

	localparam logic [TICK_W-1:0]   TICK_INTERVAL_RST  = 16'd40;
	localparam logic [FRAMES_W-1:0] FRAMES_IN_LOOP_RST = 7'd36;
	localparam logic [REPEAT_W-1:0] REPEAT_TOTAL_RST   = 8'd0;

	// command carried in tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EMIT,
		ST_ADV
	} st_t;

endpackage

// ----- design/lfap_frame_store.sv -----
// lfap_frame_store: frame store memory, one write and one registered read port
// read data holds while no read is issued
// no dependencies
module lfap_frame_store #(
	parameter int DEPTH = 2304,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lfap_shadow.sv -----
// lfap_shadow: shadow of the brightness values shown, one entry per led
// memory with per-entry valid bits; an entry not valid reads as zero
// no dependencies
module lfap_shadow #(
	parameter int DEPTH = 36,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0]       mem [DEPTH];
	logic [7:0]       rdata_q;
	logic [DEPTH-1:0] valid_q;
	logic             rd_vld_q;

	// data array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// valid bits, cleared at once by reset or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rdata_q : 8'd0;

endmodule

// ----- design/led_frame_animation_player.sv -----
// led_frame_animation_player: top level, command decode, draw sequencer, output register
// depends on lfap_pkg, lfap_frame_store, lfap_shadow
//
// Plays an LED animation out of a frame store of MAX_FRAMES x LEDS_PER_FRAME bytes.
// Load writes one byte; start rewinds and draws frame 0; each tick counts toward
// tick_interval and draws the next frame when reached; stop sends an all-off run.
// A draw first reads the frame and the shadow of shown values one led per cycle and
// compares them, then, if they differ, sends the frame as a run of LEDS_PER_FRAME
// items at one per cycle while the sink is ready (the single frame store read port
// sets this rate), then advances the frame index. Input items are taken only between
// commands; the last output item of a run may still wait in the output register while
// the next input item is taken.
module led_frame_animation_player #(
	parameter int LEDS_PER_FRAME = 36,
	parameter int MAX_FRAMES     = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lfap_pkg::S_DATA_W-1:0]   s_tdata,   // store_address[11:0], frame_byte[19:12]
	input  logic [lfap_pkg::CMD_W-1:0]      s_tuser,   // command[1:0]
	// output items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lfap_pkg::M_DATA_W-1:0]   m_tdata,   // led_number[5:0], brightness[13:6]
	output logic                            m_tlast,   // frame_end
	// configuration writes
	input  logic                            cfg_we,
	input  logic [lfap_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [lfap_pkg::REG_DATA_W-1:0] cfg_wdata
);

	import lfap_pkg::*;

	localparam int STORE_DEPTH = LEDS_PER_FRAME * MAX_FRAMES;
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int LED_AW      = (LEDS_PER_FRAME > 1) ? $clog2(LEDS_PER_FRAME) : 1;
	localparam int CNT_W       = $clog2(LEDS_PER_FRAME + 1);

	// configuration registers
	logic [TICK_W-1:0]   tick_interval_q;
	logic [FRAMES_W-1:0] frames_in_loop_q;
	logic [REPEAT_W-1:0] repeat_total_q;

	// player state
	st_t                 state_q, state_d;
	logic [INDEX_W-1:0]  frame_idx_q;
	logic [REPEAT_W-1:0] repeats_left_q;
	logic [TICK_W-1:0]   tick_cnt_q;
	logic                playing_q;

	// sequencer
	logic [CNT_W-1:0]    cnt_q;
	logic                cmp_vld_s1;
	logic                emit_vld_s1;
	logic [LED_AW-1:0]   emit_led_s1;
	logic                diff_q;
	logic                zero_run_q;

	// output register
	logic                out_vld_q;
	logic [LED_W-1:0]    out_led_q;
	logic [BYTE_W-1:0]   out_bright_q;
	logic                out_last_q;

	// input fields
	cmd_t                cmd;
	logic [ADDR_W-1:0]   store_address;
	logic [BYTE_W-1:0]   frame_byte;
	logic                accept_in;

	// memory ports
	logic                store_we, store_re;
	logic [STORE_AW-1:0] store_waddr, store_raddr;
	logic [7:0]          store_rdata;
	logic                shadow_clr, shadow_we, shadow_re;
	logic [7:0]          shadow_rdata;

	// strobes from the sequencer
	logic                issue_cmp, issue_emit, take, can_load, cmp_ne, emit_last;
	logic [LED_AW-1:0]   led_rd;
	logic                cnt_more;

	// tick and advance arithmetic
	logic [TICK_W-1:0]   tick_next;
	logic [TICK_W-1:0]   interval_eff;
	logic                tick_hit;
	logic [FRAMES_W-1:0] frames_lim;
	logic [INDEX_W-1:0]  idx_inc;
	logic                idx_wrap;

	assign cmd           = cmd_t'(s_tuser);
	assign store_address = s_tdata[ADDR_W-1:0];
	assign frame_byte    = s_tdata[ADDR_W+BYTE_W-1:ADDR_W];
	assign s_tready      = (state_q == ST_IDLE);
	assign accept_in     = s_tvalid && s_tready;

	// tick counter compare
	assign tick_next    = tick_cnt_q + TICK_W'(1);
	assign interval_eff = (tick_interval_q == '0) ? TICK_W'(1) : tick_interval_q;
	assign tick_hit     = (tick_next >= interval_eff) || (tick_next == '0);

	// loop length and index wrap
	always_comb begin
		if (frames_in_loop_q == '0) begin
			frames_lim = FRAMES_W'(1);
		end else if (32'(frames_in_loop_q) > MAX_FRAMES) begin
			frames_lim = FRAMES_W'(MAX_FRAMES);
		end else begin
			frames_lim = frames_in_loop_q;
		end
	end
	assign idx_inc  = frame_idx_q + INDEX_W'(1);
	assign idx_wrap = (FRAMES_W'(idx_inc) >= frames_lim) || (idx_inc == '0);

	// memory addressing
	assign led_rd      = cnt_q[LED_AW-1:0];
	assign cnt_more    = (32'(cnt_q) < LEDS_PER_FRAME);
	assign store_raddr = STORE_AW'(32'(frame_idx_q) * LEDS_PER_FRAME + 32'(led_rd));
	assign store_waddr = STORE_AW'(store_address);
	assign cmp_ne      = cmp_vld_s1 && (store_rdata != shadow_rdata);
	assign emit_last   = (32'(emit_led_s1) == LEDS_PER_FRAME - 1);
	assign can_load    = !out_vld_q || m_tready;

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		store_we   = 1'b0;
		store_re   = 1'b0;
		shadow_re  = 1'b0;
		shadow_we  = 1'b0;
		shadow_clr = 1'b0;
		issue_cmp  = 1'b0;
		issue_emit = 1'b0;
		take       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					unique case (cmd)
						CMD_LOAD: begin
							store_we = (32'(store_address) < STORE_DEPTH);
						end
						CMD_START: begin
							shadow_clr = playing_q;
							state_d    = ST_CMP;
						end
						CMD_STOP: begin
							shadow_clr = 1'b1;
							state_d    = ST_EMIT;
						end
						CMD_TICK: begin
							if (playing_q && tick_hit) begin
								state_d = ST_CMP;
							end
						end
						default: ;
					endcase
				end
			end
			ST_CMP: begin
				issue_cmp = cnt_more;
				store_re  = issue_cmp;
				shadow_re = issue_cmp;
				if (!cnt_more && !cmp_vld_s1) begin
					state_d = diff_q ? ST_EMIT : ST_ADV;
				end
			end
			ST_EMIT: begin
				take       = emit_vld_s1 && can_load;
				issue_emit = cnt_more && (!emit_vld_s1 || take);
				store_re   = issue_emit;
				shadow_we  = take && !zero_run_q;
				if (take && emit_last) begin
					state_d = zero_run_q ? ST_IDLE : ST_ADV;
				end
			end
			ST_ADV: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_interval_q  <= TICK_INTERVAL_RST;
			frames_in_loop_q <= FRAMES_IN_LOOP_RST;
			repeat_total_q   <= REPEAT_TOTAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_INTERVAL:  tick_interval_q  <= cfg_wdata[TICK_W-1:0];
				REG_FRAMES_IN_LOOP: frames_in_loop_q <= cfg_wdata[FRAMES_W-1:0];
				REG_REPEAT_TOTAL:   repeat_total_q   <= cfg_wdata[REPEAT_W-1:0];
				default: ;
			endcase
		end
	end

	// player and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_idx_q    <= '0;
			repeats_left_q <= '0;
			tick_cnt_q     <= '0;
			playing_q      <= 1'b0;
			cnt_q          <= '0;
			cmp_vld_s1     <= 1'b0;
			emit_vld_s1    <= 1'b0;
			diff_q         <= 1'b0;
			zero_run_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					diff_q <= 1'b0;
					if (accept_in) begin
						unique case (cmd)
							CMD_LOAD: ;
							CMD_START: begin
								playing_q      <= 1'b1;
								frame_idx_q    <= '0;
								repeats_left_q <= repeat_total_q;
								tick_cnt_q     <= '0;
								zero_run_q     <= 1'b0;
							end
							CMD_STOP: begin
								playing_q  <= 1'b0;
								tick_cnt_q <= '0;
								zero_run_q <= 1'b1;
							end
							CMD_TICK: begin
								if (playing_q) begin
									tick_cnt_q <= tick_hit ? '0 : tick_next;
									zero_run_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CMP: begin
					// read led i, compare it when the registered read data returns
					cmp_vld_s1 <= issue_cmp;
					if (issue_cmp) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (!cmp_vld_s1) begin
						cnt_q <= '0;
					end
					if (cmp_ne) begin
						diff_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (issue_emit) begin
						cnt_q       <= cnt_q + CNT_W'(1);
						emit_vld_s1 <= 1'b1;
					end else if (take) begin
						emit_vld_s1 <= 1'b0;
					end
				end
				ST_ADV: begin
					// next frame, wrap and count passes
					if (idx_wrap) begin
						frame_idx_q <= '0;
						if (repeats_left_q != '0) begin
							repeats_left_q <= repeats_left_q - REPEAT_W'(1);
							if (repeats_left_q == REPEAT_W'(1)) begin
								playing_q <= 1'b0;
							end
						end
					end else begin
						frame_idx_q <= idx_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// led number of the byte in the read register
	always_ff @(posedge clk) begin
		if (issue_emit) begin
			emit_led_s1 <= led_rd;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_led_q    <= LED_W'(emit_led_s1);
			out_bright_q <= zero_run_q ? '0 : store_rdata;
			out_last_q   <= emit_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = M_DATA_W'({out_bright_q, out_led_q});
	assign m_tlast  = out_last_q;

	lfap_frame_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (STORE_AW)
	) u_frame_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (frame_byte),
		.re    (store_re),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	lfap_shadow #(
		.DEPTH (LEDS_PER_FRAME),
		.AW    (LED_AW)
	) u_shadow (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (shadow_clr),
		.we     (shadow_we),
		.waddr  (emit_led_s1),
		.wdata  (store_rdata),
		.re     (shadow_re),
		.raddr  (led_rd),
		.rdata  (shadow_rdata)
	);

endmodule

// ----- design/lfap_checker.sv -----
// lfap_checker: port-level assertions for the led frame animation player
// depends on lfap_pkg; bound to led_frame_animation_player below
module lfap_checker #(
	parameter int LEDS_PER_FRAME = 36
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [lfap_pkg::CMD_W-1:0]    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lfap_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	import lfap_pkg::*;

	// a stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// a load never blocks the next item
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> s_tready)
		else $error("input not ready after load");

	// start and stop always begin work that holds off input
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && ((s_tuser == CMD_START) || (s_tuser == CMD_STOP))
		|=> !s_tready)
		else $error("input ready right after start or stop");

	// the run ends on the highest led
	a_last_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[LED_W-1:0] == LED_W'(LEDS_PER_FRAME - 1))
		else $error("frame end on wrong led");

endmodule

bind led_frame_animation_player lfap_checker #(
	.LEDS_PER_FRAME (LEDS_PER_FRAME)
) u_lfap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
